/* design/wsts_pkg.sv */
package wsts_pkg;

   localparam int TOTAL_BITS = 25;
   localparam int LEAF_BITS  = 9;
   localparam int OP_BITS    = 3;
   localparam int CSR_BITS   = 4;
   localparam int FRAC_BITS  = 16;
   localparam int WIN_BITS   = 16;
   localparam logic [CSR_BITS-1:0] LEVELS_RESET = 4'd9;
   localparam logic [CSR_BITS-1:0] LEVELS_MIN   = 4'd3;

   localparam logic [OP_BITS-1:0] OP_SET_PATH  = 3'd0;
   localparam logic [OP_BITS-1:0] OP_SET_ROOT  = 3'd1;
   localparam logic [OP_BITS-1:0] OP_REBUILD   = 3'd2;
   localparam logic [OP_BITS-1:0] OP_SAMPLE    = 3'd3;
   localparam logic [OP_BITS-1:0] OP_CLEAR     = 3'd4;

   typedef enum logic [12:0] {
      ST_CLRR  = 13'b0000000000001,
      ST_IDLE  = 13'b0000000000010,
      ST_CLR   = 13'b0000000000100,
      ST_SET   = 13'b0000000001000,
      ST_UP    = 13'b0000000010000,
      ST_ADJRD = 13'b0000000100000,
      ST_ADJ   = 13'b0000001000000,
      ST_RBRD  = 13'b0000010000000,
      ST_RBWR  = 13'b0000100000000,
      ST_MUL   = 13'b0001000000000,
      ST_WALK  = 13'b0010000000000,
      ST_HIT   = 13'b0100000000000,
      ST_DONE  = 13'b1000000000000
   } state_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_CLR,
      CMD_SET,
      CMD_UP,
      CMD_ADJRD,
      CMD_ADJ,
      CMD_RBRD,
      CMD_RBWR,
      CMD_MUL,
      CMD_WALK,
      CMD_HIT
   } cmd_type;

   typedef struct packed {
      logic up_last;
      logic rb_last;
      logic walk_leaf;
      logic clr_last;
   } status_type;

endpackage

/* design/wsts_ctrl.sv */
module wsts_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [wsts_pkg::OP_BITS-1:0]    req_opcode,
   input  wsts_pkg::status_type            status,
   output wsts_pkg::cmd_type               cmd,
   output logic                            busy,
   output logic                            rsp_valid
);

   wsts_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wsts_pkg::ST_CLRR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = wsts_pkg::CMD_NONE;
      unique case (state_ff)
         wsts_pkg::ST_IDLE, wsts_pkg::ST_DONE: begin
            state_in = wsts_pkg::ST_IDLE;
            if (start) begin
               cmd = wsts_pkg::CMD_LOAD;
               unique case (req_opcode)
                  wsts_pkg::OP_SET_PATH: state_in = wsts_pkg::ST_SET;
                  wsts_pkg::OP_SET_ROOT: state_in = wsts_pkg::ST_ADJRD;
                  wsts_pkg::OP_REBUILD:  state_in = wsts_pkg::ST_RBRD;
                  wsts_pkg::OP_SAMPLE:   state_in = wsts_pkg::ST_MUL;
                  wsts_pkg::OP_CLEAR:    state_in = wsts_pkg::ST_CLR;
                  default:               state_in = wsts_pkg::ST_DONE;
               endcase
            end
         end
         wsts_pkg::ST_CLRR: begin
            cmd = wsts_pkg::CMD_CLR;
            if (status.clr_last) state_in = wsts_pkg::ST_IDLE;
         end
         wsts_pkg::ST_CLR: begin
            cmd = wsts_pkg::CMD_CLR;
            if (status.clr_last) state_in = wsts_pkg::ST_DONE;
         end
         wsts_pkg::ST_SET: begin
            cmd      = wsts_pkg::CMD_SET;
            state_in = wsts_pkg::ST_UP;
         end
         wsts_pkg::ST_UP: begin
            cmd = wsts_pkg::CMD_UP;
            if (status.up_last) state_in = wsts_pkg::ST_DONE;
         end
         wsts_pkg::ST_ADJRD: begin
            cmd      = wsts_pkg::CMD_ADJRD;
            state_in = wsts_pkg::ST_ADJ;
         end
         wsts_pkg::ST_ADJ: begin
            cmd      = wsts_pkg::CMD_ADJ;
            state_in = wsts_pkg::ST_DONE;
         end
         wsts_pkg::ST_RBRD: begin
            cmd      = wsts_pkg::CMD_RBRD;
            state_in = wsts_pkg::ST_RBWR;
         end
         wsts_pkg::ST_RBWR: begin
            cmd      = wsts_pkg::CMD_RBWR;
            state_in = status.rb_last ? wsts_pkg::ST_DONE : wsts_pkg::ST_RBRD;
         end
         wsts_pkg::ST_MUL: begin
            cmd      = wsts_pkg::CMD_MUL;
            state_in = wsts_pkg::ST_WALK;
         end
         wsts_pkg::ST_WALK: begin
            cmd = wsts_pkg::CMD_WALK;
            if (status.walk_leaf) state_in = wsts_pkg::ST_HIT;
         end
         wsts_pkg::ST_HIT: begin
            cmd      = wsts_pkg::CMD_HIT;
            state_in = wsts_pkg::ST_DONE;
         end
         default: begin
            state_in = wsts_pkg::ST_CLRR;
         end
      endcase
   end

   assign busy      = (state_ff != wsts_pkg::ST_IDLE) && (state_ff != wsts_pkg::ST_DONE);
   assign rsp_valid = (state_ff == wsts_pkg::ST_DONE);

endmodule

/* design/wsts_datapath.sv */
module wsts_datapath #(
   parameter int MAX_LEAVES  = 512,
   parameter int WEIGHT_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  wsts_pkg::cmd_type                 cmd,
   output wsts_pkg::status_type              status,
   input  logic [wsts_pkg::LEAF_BITS-1:0]    req_leaf_index,
   input  logic [wsts_pkg::WIN_BITS-1:0]     req_weight,
   input  logic [wsts_pkg::FRAC_BITS-1:0]    req_random_fraction,
   input  logic                              csr_valid,
   input  logic [wsts_pkg::CSR_BITS-1:0]     csr_tree_levels,
   output logic [wsts_pkg::LEAF_BITS-1:0]    rsp_chosen_leaf,
   output logic                              rsp_zero_weight_hit,
   output logic [wsts_pkg::TOTAL_BITS-1:0]   rsp_total_weight
);

   localparam int LOG_MAX = $clog2(MAX_LEAVES);
   localparam int DEPTH   = 2 * MAX_LEAVES;
   localparam int AW      = $clog2(DEPTH);
   localparam int NW      = LOG_MAX + WEIGHT_BITS;
   localparam logic [NW:0] MAXL     = (NW+1)'(MAX_LEAVES);
   localparam logic [NW:0] NODE_MAX = (MAXL << WEIGHT_BITS) - MAXL;
   localparam logic [wsts_pkg::WIN_BITS-1:0] WMASK =
      (WEIGHT_BITS >= wsts_pkg::WIN_BITS) ? '1 : wsts_pkg::WIN_BITS'((1 << WEIGHT_BITS) - 1);
   localparam logic [wsts_pkg::CSR_BITS-1:0] LEVELS_TOP = wsts_pkg::CSR_BITS'(LOG_MAX);

   function automatic logic [NW-1:0] sat_add(input logic [NW-1:0] a, input logic [NW-1:0] b);
      logic [NW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s > NODE_MAX) ? NW'(NODE_MAX) : NW'(s);
   endfunction

   logic [NW-1:0] mem [0:DEPTH-1];
   logic [NW-1:0] rd0_ff, rd1_ff;

   logic [wsts_pkg::CSR_BITS-1:0]  levels_ff;
   logic [wsts_pkg::LEAF_BITS-1:0] leaf_ff;
   logic [NW-1:0]                  wv_ff;
   logic [wsts_pkg::FRAC_BITS-1:0] frac_ff;
   logic [AW-1:0]                  cnt_ff, cur_ff, i_ff;
   logic [NW-1:0]                  val_ff, r_ff, root_ff;
   logic [wsts_pkg::LEAF_BITS-1:0] chosen_ff;
   logic                           hit_ff;

   logic [wsts_pkg::CSR_BITS-1:0] lv;
   logic [AW-1:0]   n, p, par;
   logic            we;
   logic [AW-1:0]   waddr, raddr0, raddr1;
   logic [NW-1:0]   wdata, sum_up, sum_rb, radj;
   logic [NW:0]     rw;
   logic [NW+15:0]  prod;
   logic            go;
   logic [AW:0]     jx;

   always_comb begin
      if (levels_ff < wsts_pkg::LEVELS_MIN) begin
         lv = wsts_pkg::LEVELS_MIN;
      end else if (levels_ff > LEVELS_TOP) begin
         lv = LEVELS_TOP;
      end else begin
         lv = levels_ff;
      end
   end

   assign n      = AW'(1) << lv;
   assign p      = n + (AW'(leaf_ff) & (n - AW'(1)));
   assign par    = cur_ff >> 1;
   assign sum_up = sat_add(val_ff, rd0_ff);
   assign sum_rb = sat_add(rd0_ff, rd1_ff);
   assign rw     = {1'b0, root_ff} + {1'b0, wv_ff};
   assign prod   = (NW+16)'(frac_ff) * (NW+16)'(root_ff);
   assign go     = r_ff > rd0_ff;
   assign jx     = {1'b0, i_ff} + (AW+1)'(go);

   // Root-only adjust: old weight comes back while the new one is written.
   always_comb begin
      if (rw >= {1'b0, rd0_ff}) begin
         radj = ((rw - {1'b0, rd0_ff}) > NODE_MAX) ? NW'(NODE_MAX) : NW'(rw - {1'b0, rd0_ff});
      end else begin
         radj = '0;
      end
   end

   always_comb begin
      we     = 1'b0;
      waddr  = '0;
      wdata  = '0;
      raddr0 = '0;
      raddr1 = '0;
      unique case (cmd)
         wsts_pkg::CMD_CLR: begin
            we    = 1'b1;
            waddr = cnt_ff;
         end
         wsts_pkg::CMD_SET: begin
            we     = 1'b1;
            waddr  = p;
            wdata  = wv_ff;
            raddr0 = p ^ AW'(1);
         end
         wsts_pkg::CMD_UP: begin
            we     = 1'b1;
            waddr  = par;
            wdata  = sum_up;
            raddr0 = par ^ AW'(1);
         end
         wsts_pkg::CMD_ADJRD: begin
            we     = 1'b1;
            waddr  = p;
            wdata  = wv_ff;
            raddr0 = p;
         end
         wsts_pkg::CMD_ADJ: begin
            we    = 1'b1;
            waddr = AW'(1);
            wdata = radj;
         end
         wsts_pkg::CMD_RBRD: begin
            raddr0 = i_ff << 1;
            raddr1 = (i_ff << 1) | AW'(1);
         end
         wsts_pkg::CMD_RBWR: begin
            we    = 1'b1;
            waddr = i_ff;
            wdata = sum_rb;
         end
         wsts_pkg::CMD_MUL: begin
            raddr0 = AW'(2);
         end
         wsts_pkg::CMD_WALK: begin
            raddr0 = (i_ff < n) ? AW'(jx << 1) : AW'(jx);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd0_ff <= mem[raddr0];
      rd1_ff <= mem[raddr1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         levels_ff <= wsts_pkg::LEVELS_RESET;
         cnt_ff    <= '0;
         root_ff   <= '0;
      end else begin
         if (csr_valid) levels_ff <= csr_tree_levels;
         if (we && waddr == AW'(1)) root_ff <= wdata;
         if (cmd == wsts_pkg::CMD_CLR) cnt_ff <= cnt_ff + AW'(1);
         if (cmd == wsts_pkg::CMD_LOAD) cnt_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd)
         wsts_pkg::CMD_LOAD: begin
            leaf_ff   <= req_leaf_index;
            wv_ff     <= NW'(req_weight & WMASK);
            frac_ff   <= req_random_fraction;
            chosen_ff <= '0;
            hit_ff    <= 1'b0;
            i_ff      <= n - AW'(1);
         end
         wsts_pkg::CMD_SET: begin
            cur_ff <= p;
            val_ff <= wv_ff;
         end
         wsts_pkg::CMD_UP: begin
            cur_ff <= par;
            val_ff <= sum_up;
         end
         wsts_pkg::CMD_RBWR: begin
            i_ff <= i_ff - AW'(1);
         end
         wsts_pkg::CMD_MUL: begin
            r_ff <= NW'(prod >> wsts_pkg::FRAC_BITS);
            i_ff <= AW'(2);
         end
         wsts_pkg::CMD_WALK: begin
            if (go) r_ff <= r_ff - rd0_ff;
            if (i_ff < n) begin
               i_ff <= AW'(jx << 1);
            end else begin
               i_ff      <= AW'(jx);
               chosen_ff <= wsts_pkg::LEAF_BITS'(jx - {1'b0, n});
            end
         end
         wsts_pkg::CMD_HIT: begin
            hit_ff <= (rd0_ff == '0);
         end
         default: begin
         end
      endcase
   end

   assign status.up_last   = (par == AW'(1));
   assign status.rb_last   = (i_ff == AW'(1));
   assign status.walk_leaf = (i_ff >= n);
   assign status.clr_last  = &cnt_ff;

   assign rsp_chosen_leaf     = chosen_ff;
   assign rsp_zero_weight_hit = hit_ff;
   assign rsp_total_weight    = wsts_pkg::TOTAL_BITS'(root_ff);

endmodule

/* design/weighted_sum_tree_sampler.sv */
// Weighted sum-tree sampler. One command word is taken when start is high and busy is low;
// its single result word appears on the rsp_ ports for one cycle with rsp_valid, and the
// receiver cannot stall it. The tree lives in a one-write, two-read memory of 2*MAX_LEAVES
// nodes with registered reads, so the cost per word is set by memory accesses: set and
// update path writes one node per cycle on the way up, set with root adjust writes the
// leaf and then the root, sample reads one level per cycle on the way down, rebuild
// writes each inner node from its two children, clear writes every node, and unused
// codes do no work. After reset the block clears the memory with busy high. The csr_
// channel is always ready; write tree_levels only while idle and follow it with a clear.
module weighted_sum_tree_sampler #(
   parameter int MAX_LEAVES  = 512,
   parameter int WEIGHT_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [wsts_pkg::OP_BITS-1:0]      req_opcode,
   input  logic [wsts_pkg::LEAF_BITS-1:0]    req_leaf_index,
   input  logic [wsts_pkg::WIN_BITS-1:0]     req_weight,
   input  logic [wsts_pkg::FRAC_BITS-1:0]    req_random_fraction,
   output logic                              rsp_valid,
   output logic [wsts_pkg::LEAF_BITS-1:0]    rsp_chosen_leaf,
   output logic                              rsp_zero_weight_hit,
   output logic [wsts_pkg::TOTAL_BITS-1:0]   rsp_total_weight,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [wsts_pkg::CSR_BITS-1:0]     csr_tree_levels
);

   wsts_pkg::cmd_type    cmd;
   wsts_pkg::status_type status;

   assign csr_ready = 1'b1;

   wsts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_valid  (rsp_valid)
   );

   wsts_datapath #(
      .MAX_LEAVES  (MAX_LEAVES),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_leaf_index      (req_leaf_index),
      .req_weight          (req_weight),
      .req_random_fraction (req_random_fraction),
      .csr_valid           (csr_valid & csr_ready),
      .csr_tree_levels     (csr_tree_levels),
      .rsp_chosen_leaf     (rsp_chosen_leaf),
      .rsp_zero_weight_hit (rsp_zero_weight_hit),
      .rsp_total_weight    (rsp_total_weight)
   );

endmodule

/* design/wsts_checker.sv */
module wsts_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   // The clearing pass after reset holds off commands.
   a_reset_busy: assert property (@(posedge clock) reset |=> busy)
      else $error("busy not raised after reset");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result word shown while busy");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted word neither worked on nor answered");

   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !start) |=> !rsp_valid)
      else $error("result word repeated");

   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      (!busy && !rsp_valid && !start) |=> !rsp_valid)
      else $error("result word without a command");

endmodule

bind weighted_sum_tree_sampler wsts_checker u_wsts_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);
